### design/tri_noise_dmc_nonlinear_mixer_core_macros.svh
// Assertion macros for the triangle, noise and delta-modulation mixer core.
// Used by the port checker; each macro expects clk_i and rst_ni in scope.
`ifndef TRI_NOISE_DMC_NONLINEAR_MIXER_CORE_MACROS_SVH
`define TRI_NOISE_DMC_NONLINEAR_MIXER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TND_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// The consequent must hold in the cycle after the antecedent.
`define TND_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

### design/tnd_pkg.sv
// Shared types and constants for the triangle, noise and delta-modulation mixer.
// No dependencies; used by the controller, the datapath and the top level.
package tnd_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int INT_BITS      = 10;

  localparam int TRI_W   = 4;
  localparam int NOI_W   = 4;
  localparam int DMC_W   = 7;
  localparam int LEVEL_W = 7;
  localparam int DELTA_W = 8;
  localparam int REQ_W   = 2;
  localparam int PIN_W   = 17;

  localparam logic [REQ_W-1:0] REQ_TRI = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOI = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DMC = 2'd2;

  localparam logic [LEVEL_W-1:0] TRI_MAX = 7'd15;
  localparam logic [LEVEL_W-1:0] NOI_MAX = 7'd15;
  localparam logic [LEVEL_W-1:0] DMC_MAX = 7'd127;

  localparam int PT_W  = 33;
  localparam int PN_W  = 32;
  localparam int PD_W  = 34;
  localparam int X_W   = 35;
  localparam int DEN_W = 42;
  localparam int NUM_W = 51;
  localparam int REM_W = NUM_W + 1;

  localparam logic [28:0] TRI_WEIGHT = 29'd277111758;
  localparam logic [27:0] NOI_WEIGHT = 28'd186242826;
  localparam logic [26:0] DMC_WEIGHT = 27'd100706707;
  localparam logic [DEN_W-1:0] MIX_DENOM = 42'd2279798433066;
  localparam logic [15:0] PIN_GAIN = 16'd63916;
  localparam logic [6:0]  DEN_GAIN = 7'd100;
  localparam logic [PIN_W-1:0] PIN_MAX = 17'h1FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGH,
    ST_SUM,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic weigh;
    logic sum;
    logic scale;
    logic step;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

### design/tnd_ctrl.sv
// Controller state machine for the mixer core.
// Depends on tnd_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
module tnd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tnd_pkg::dp_cmd_t  cmd_o,
  input  tnd_pkg::dp_sts_t  sts_i
);
  import tnd_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_WEIGH;
      ST_WEIGH: state_d = ST_SUM;
      ST_SUM:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_last) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_WEIGH: cmd_o.weigh = 1'b1;
      ST_SUM:   cmd_o.sum   = 1'b1;
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_DIV:   cmd_o.step  = 1'b1;
      ST_DONE:  cmd_o.load  = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### design/tnd_datapath.sv
// Datapath of the mixer core: channel levels, weighting, scaling and the
// restoring divider, plus the result register. Depends on tnd_pkg.
module tnd_datapath #(
  parameter int FracBits = tnd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tnd_pkg::dp_cmd_t               cmd_i,
  output tnd_pkg::dp_sts_t               sts_o,
  input  logic [tnd_pkg::REQ_W-1:0]      req_type_i,
  input  logic signed [tnd_pkg::DELTA_W-1:0] delta_i,
  output logic [tnd_pkg::LEVEL_W-1:0]    level_o,
  output logic [tnd_pkg::PIN_W-1:0]      pin_out_o
);
  import tnd_pkg::*;

  localparam int QW   = INT_BITS + FracBits;
  localparam int CW   = $clog2(QW);
  localparam int EXTW = QW + PIN_W;

  function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] cur,
                                                 input logic signed [DELTA_W-1:0] off,
                                                 input logic [LEVEL_W-1:0] max);
    logic signed [LEVEL_W+1:0] sum;
    sum = $signed({2'b00, cur}) + (LEVEL_W+2)'(off);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, max})) begin
      return max;
    end else begin
      return sum[LEVEL_W-1:0];
    end
  endfunction

  logic [TRI_W-1:0]   tri_q;
  logic [NOI_W-1:0]   noi_q;
  logic [DMC_W-1:0]   dmc_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [LEVEL_W-1:0] tri_new, noi_new, dmc_new;

  logic [PT_W-1:0]  pt_q;
  logic [PN_W-1:0]  pn_q;
  logic [PD_W-1:0]  pd_q;
  logic [X_W-1:0]   x_q;
  logic [DEN_W-1:0] den_q;
  logic [REM_W-1:0] rem_q;
  logic [QW-1:0]    quo_q;
  logic [CW-1:0]    cnt_q;

  logic [REM_W-1:0] dsor;
  logic             ge;
  logic [REM_W-1:0] rem_sub;
  logic [EXTW-1:0]  quo_ext;
  logic [PIN_W-1:0] pin_sat;

  logic [LEVEL_W-1:0] level_q;
  logic [PIN_W-1:0]   pin_q;

  assign tri_new = sat_add(LEVEL_W'(tri_q), delta_i, TRI_MAX);
  assign noi_new = sat_add(LEVEL_W'(noi_q), delta_i, NOI_MAX);
  assign dmc_new = sat_add(dmc_q, delta_i, DMC_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q <= '0;
      noi_q <= '0;
      dmc_q <= '0;
    end else if (cmd_i.accept) begin
      unique case (req_type_i)
        REQ_TRI: tri_q <= tri_new[TRI_W-1:0];
        REQ_NOI: noi_q <= noi_new[NOI_W-1:0];
        REQ_DMC: dmc_q <= dmc_new;
        default: ;
      endcase
    end
  end

  assign dsor    = {1'b0, den_q, {(NUM_W-DEN_W){1'b0}}};
  assign ge      = rem_q >= dsor;
  assign rem_sub = ge ? (rem_q - dsor) : rem_q;
  assign quo_ext = EXTW'(quo_q);
  assign pin_sat = (quo_ext > EXTW'(PIN_MAX)) ? PIN_MAX : quo_ext[PIN_W-1:0];

  assign sts_o.div_last = (cnt_q == CW'(QW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      unique case (req_type_i)
        REQ_TRI: lvl_q <= tri_new;
        REQ_NOI: lvl_q <= noi_new;
        REQ_DMC: lvl_q <= dmc_new;
        default: lvl_q <= '0;
      endcase
    end
    if (cmd_i.weigh) begin
      pt_q <= PT_W'(tri_q) * PT_W'(TRI_WEIGHT);
      pn_q <= PN_W'(noi_q) * PN_W'(NOI_WEIGHT);
      pd_q <= PD_W'(dmc_q) * PD_W'(DMC_WEIGHT);
    end
    if (cmd_i.sum) begin
      x_q <= X_W'(pt_q) + X_W'(pn_q) + X_W'(pd_q);
    end
    if (cmd_i.scale) begin
      den_q <= DEN_W'(x_q) * DEN_W'(DEN_GAIN) + MIX_DENOM;
      rem_q <= REM_W'(NUM_W'(x_q) * NUM_W'(PIN_GAIN));
      quo_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.step) begin
      rem_q <= {rem_sub[REM_W-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.load) begin
      level_q <= lvl_q;
      pin_q   <= pin_sat;
    end
  end

  assign level_o   = level_q;
  assign pin_out_o = pin_q;

endmodule

### design/tri_noise_dmc_nonlinear_mixer_core.sv
// Top level of the triangle, noise and delta-modulation nonlinear mixer core.
// Each item runs through the weigh, sum, scale and divide states, and no new
// item is taken before its result is loaded. The restoring divider sets the pace,
// as it retires one quotient bit per cycle (10 integer bits plus FracBits).
// Reset clears all three channel levels and the control state at once.
module tri_noise_dmc_nonlinear_mixer_core #(
  parameter int FracBits = tnd_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [tnd_pkg::REQ_W-1:0]          req_type_i,
  input  logic signed [tnd_pkg::DELTA_W-1:0] delta_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tnd_pkg::LEVEL_W-1:0]        level_o,
  output logic [tnd_pkg::PIN_W-1:0]          pin_out_o
);
  import tnd_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  tnd_datapath #(
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_type_i),
    .delta_i    (delta_i),
    .level_o    (level_o),
    .pin_out_o  (pin_out_o)
  );

endmodule

### design/tnd_checker.sv
// Port-level checker for the mixer core, attached to the top level by bind.
// Depends on tnd_pkg and the assertion macro header.
`include "tri_noise_dmc_nonlinear_mixer_core_macros.svh"

module tnd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tnd_pkg::LEVEL_W-1:0] level_o,
  input logic [tnd_pkg::PIN_W-1:0]   pin_out_o
);

  `TND_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(level_o) && $stable(pin_out_o))
  `TND_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `TND_ASSERT_SAME(a_result_frees_input, $rose(out_valid_o), in_ready_o)

endmodule

bind tri_noise_dmc_nonlinear_mixer_core tnd_checker u_tnd_checker (.*);
